/* design/lpht_pkg.sv */
package lpht_pkg;

    localparam int INIT_CAPACITY = 16;
    localparam int MAX_CAPACITY  = 1024;
    localparam int SLOTS         = (MAX_CAPACITY > INIT_CAPACITY) ? MAX_CAPACITY : INIT_CAPACITY;
    localparam int IDX_W         = $clog2(SLOTS);
    localparam int ADDR_W        = IDX_W + 1;
    localparam int CNT_W         = 11;
    localparam int KEY_W         = 32;
    localparam int VAL_W         = 32;
    localparam int HASH_W        = 32;
    localparam int OP_W          = 2;

    typedef enum logic [OP_W-1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef struct packed {
        logic              occ;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  val;
        logic [HASH_W-1:0] hash;
    } t_entry;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_INS,
        S_RSZ,
        S_RB_CLR,
        S_RB_RD,
        S_RB_CHK,
        S_RB_NXT,
        S_RBP_RD,
        S_RBP_CHK,
        S_RB_END,
        S_PL_START,
        S_PL_RD,
        S_PL_CHK,
        S_PR_RD,
        S_PR_CHK,
        S_RM_TOP,
        S_RM_CHK,
        S_RM_END,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic inc_cnt;
        logic dec_cnt;
        logic set_full;
        logic rb_start;
        logic clr;
        logic rb_rd;
        logic rb_take;
        logic rb_inc;
        logic rbp_rd;
        logic rb_wr;
        logic rb_end;
        logic pl_start;
        logic pl_rd;
        logic pl_wr;
        logic pr_rd;
        logic adv;
        logic set_found;
        logic rm_start;
        logic rm_rd;
        logic rm_step;
        logic rm_end;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic need_rsz;
        logic clr_last;
        logic occ;
        logic key_eq_req;
        logic key_eq_rb;
        logic n_last;
        logic i_last;
        logic rm_done;
        logic move;
    } t_sts;

    // smallest power of two not below max(1,count), doubled, clamped
    function automatic logic [CNT_W-1:0] rel_cap(input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] n1;
        logic [CNT_W+1:0] p;
        int               l;
        n1 = (count == '0) ? '0 : count - 1'b1;
        l  = 0;
        for (int i = 0; i < CNT_W; i++) begin
            if (n1[i]) l = i + 1;
        end
        p = (CNT_W+2)'(1) << (l + 1);
        if (p < (CNT_W+2)'(INIT_CAPACITY)) p = (CNT_W+2)'(INIT_CAPACITY);
        if (p > (CNT_W+2)'(MAX_CAPACITY)) p = (CNT_W+2)'(MAX_CAPACITY);
        return p[CNT_W-1:0];
    endfunction

endpackage

/* design/lpht_dp.sv */
module lpht_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lpht_pkg::t_cmd            i_cmd,
    output lpht_pkg::t_sts            o_sts,
    input  logic [1:0]                i_op,
    input  logic [31:0]               i_key,
    input  logic [31:0]               i_key_hash,
    input  logic [31:0]               i_payload,
    output logic                      o_hit,
    output logic                      o_full_res,
    output logic [31:0]               o_found_value,
    output logic [10:0]               o_entry_count,
    output logic [10:0]               o_table_capacity
);
    import lpht_pkg::*;

    t_entry            r_mem [0:2*SLOTS-1];
    t_entry            r_rd;

    t_op               r_op;
    logic [KEY_W-1:0]  r_key;
    logic [HASH_W-1:0] r_hash;
    logic [VAL_W-1:0]  r_val;
    logic [KEY_W-1:0]  r_ekey;
    logic [HASH_W-1:0] r_ehash;
    logic [VAL_W-1:0]  r_eval;

    logic              r_half;
    logic              r_thalf;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_newcap;
    logic [IDX_W-1:0]  r_clr;
    logic [IDX_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_b;
    logic [CNT_W-1:0]  r_mask;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_prev;
    logic [CNT_W-1:0]  r_cur;
    logic              r_hit;
    logic              r_full;
    logic [VAL_W-1:0]  r_found;

    logic [CNT_W-1:0]  rel;
    logic [CNT_W-1:0]  native;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;

    assign rel    = rel_cap(r_count);
    assign native = r_rd.hash[CNT_W-1:0] & r_mask;

    always_comb begin
        o_sts.op         = r_op;
        o_sts.full       = (r_count >= CNT_W'(MAX_CAPACITY));
        o_sts.need_rsz   = (rel > r_cap) || (rel < (r_cap >> 1));
        o_sts.clr_last   = (CNT_W'(r_clr) == r_newcap - 1'b1);
        o_sts.occ        = r_rd.occ;
        o_sts.key_eq_req = (r_rd.key == r_key);
        o_sts.key_eq_rb  = (r_rd.key == r_ekey);
        o_sts.n_last     = (r_n == r_mask);
        o_sts.i_last     = (CNT_W'(r_i) == r_cap - 1'b1);
        o_sts.rm_done    = (r_n > r_mask);
        o_sts.move       = ((r_prev < r_cur) && ((native <= r_prev) || (native > r_cur))) ||
                           ((r_prev > r_cur) && (native <= r_prev) && (native > r_cur));
    end

    always_comb begin
        rd_en   = i_cmd.rb_rd | i_cmd.rbp_rd | i_cmd.pl_rd | i_cmd.pr_rd | i_cmd.rm_rd;
        rd_addr = {r_half, r_b[IDX_W-1:0]};
        if (i_cmd.rb_rd) begin
            rd_addr = {r_half, r_i};
        end else if (i_cmd.rbp_rd) begin
            rd_addr = {r_thalf, r_b[IDX_W-1:0]};
        end else if (i_cmd.rm_rd) begin
            rd_addr = {r_half, r_cur[IDX_W-1:0]};
        end
        wr_en   = 1'b0;
        wr_addr = {r_thalf, r_clr};
        wr_data = '0;
        if (i_cmd.clr) begin
            wr_en = 1'b1;
        end else if (i_cmd.rb_wr) begin
            wr_en   = 1'b1;
            wr_addr = {r_thalf, r_b[IDX_W-1:0]};
            wr_data = '{occ: 1'b1, key: r_ekey, val: r_eval, hash: r_ehash};
        end else if (i_cmd.pl_wr) begin
            wr_en   = 1'b1;
            wr_addr = {r_half, r_b[IDX_W-1:0]};
            wr_data = '{occ: 1'b1, key: r_key, val: r_val, hash: r_hash};
        end else if (i_cmd.rm_step && o_sts.move) begin
            wr_en   = 1'b1;
            wr_addr = {r_half, r_prev[IDX_W-1:0]};
            wr_data = r_rd;
        end else if (i_cmd.rm_end) begin
            wr_en   = 1'b1;
            wr_addr = {r_half, r_prev[IDX_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half   <= 1'b0;
            r_thalf  <= 1'b0;
            r_count  <= '0;
            r_cap    <= CNT_W'(INIT_CAPACITY);
            r_newcap <= CNT_W'(INIT_CAPACITY);
            r_clr    <= '0;
            r_op     <= OP_NOP;
        end else begin
            if (i_cmd.load) begin
                r_op    <= t_op'(i_op);
                r_key   <= i_key;
                r_hash  <= i_key_hash;
                r_val   <= i_payload;
                r_b     <= i_key_hash[CNT_W-1:0] & (r_cap - 1'b1);
                r_mask  <= r_cap - 1'b1;
                r_n     <= '0;
                r_hit   <= 1'b0;
                r_full  <= 1'b0;
                r_found <= '0;
            end
            if (i_cmd.inc_cnt) r_count <= r_count + 1'b1;
            if (i_cmd.dec_cnt) r_count <= r_count - 1'b1;
            if (i_cmd.set_full) r_full <= 1'b1;
            if (i_cmd.rb_start) begin
                r_newcap <= rel;
                r_thalf  <= ~r_half;
                r_clr    <= '0;
                r_i      <= '0;
            end
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.rb_take) begin
                r_ekey  <= r_rd.key;
                r_eval  <= r_rd.val;
                r_ehash <= r_rd.hash;
                r_b     <= r_rd.hash[CNT_W-1:0] & (r_newcap - 1'b1);
                r_mask  <= r_newcap - 1'b1;
                r_n     <= '0;
            end
            if (i_cmd.rb_inc) r_i <= r_i + 1'b1;
            if (i_cmd.rb_end) begin
                r_cap  <= r_newcap;
                r_half <= r_thalf;
            end
            if (i_cmd.pl_start) begin
                r_b    <= r_hash[CNT_W-1:0] & (r_cap - 1'b1);
                r_mask <= r_cap - 1'b1;
                r_n    <= '0;
            end
            if (i_cmd.pl_wr) r_hit <= 1'b1;
            if (i_cmd.adv) begin
                r_b <= (r_b + 1'b1) & r_mask;
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.set_found) begin
                r_hit   <= 1'b1;
                r_found <= r_rd.val;
            end
            if (i_cmd.rm_start) begin
                r_prev <= r_b;
                r_cur  <= (r_b + 1'b1) & r_mask;
                r_n    <= CNT_W'(1);
            end
            if (i_cmd.rm_step) begin
                if (o_sts.move) r_prev <= r_cur;
                r_cur <= (r_cur + 1'b1) & r_mask;
                r_n   <= r_n + 1'b1;
            end
            if (i_cmd.rm_end) begin
                r_hit <= 1'b1;
                if (r_count != '0) r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_hit            <= r_hit;
            o_full_res       <= r_full;
            o_found_value    <= r_found;
            o_entry_count    <= r_count;
            o_table_capacity <= r_cap;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CAPACITY))
        else $error("entry count above maximum");
    a_cap_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_cap) && r_cap >= CNT_W'(INIT_CAPACITY) && r_cap <= CNT_W'(MAX_CAPACITY))
        else $error("capacity out of range");
    a_half_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rb_end |=> r_half != $past(r_half))
        else $error("rebuild did not swap halves");
    a_clr_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rb_wr |-> r_thalf != r_half)
        else $error("rebuild writing into live half");

endmodule

/* design/lpht_ctrl.sv */
module lpht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_op,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  lpht_pkg::t_sts i_sts,
    output lpht_pkg::t_cmd o_cmd
);
    import lpht_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (t_op'(i_op))
                        OP_FIND, OP_REMOVE: n_state = S_PR_RD;
                        OP_INSERT:          n_state = S_INS;
                        default:            n_state = S_RESP;
                    endcase
                end
            end
            S_INS: begin
                if (i_sts.full) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.inc_cnt = 1'b1;
                    n_state       = S_RSZ;
                end
            end
            S_RSZ: begin
                if (i_sts.need_rsz) begin
                    o_cmd.rb_start = 1'b1;
                    n_state        = S_RB_CLR;
                end else if (i_sts.op == OP_INSERT) begin
                    n_state = S_PL_START;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RB_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_RB_RD;
            end
            S_RB_RD: begin
                o_cmd.rb_rd = 1'b1;
                n_state     = S_RB_CHK;
            end
            S_RB_CHK: begin
                if (i_sts.occ) begin
                    o_cmd.rb_take = 1'b1;
                    n_state       = S_RBP_RD;
                end else begin
                    n_state = S_RB_NXT;
                end
            end
            S_RB_NXT: begin
                if (i_sts.i_last) begin
                    n_state = S_RB_END;
                end else begin
                    o_cmd.rb_inc = 1'b1;
                    n_state      = S_RB_RD;
                end
            end
            S_RBP_RD: begin
                o_cmd.rbp_rd = 1'b1;
                n_state      = S_RBP_CHK;
            end
            S_RBP_CHK: begin
                if (!i_sts.occ) begin
                    o_cmd.rb_wr = 1'b1;
                    n_state     = S_RB_NXT;
                end else if (i_sts.key_eq_rb || i_sts.n_last) begin
                    // drop duplicate or unplaceable entry
                    n_state = S_RB_NXT;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_RBP_RD;
                end
            end
            S_RB_END: begin
                o_cmd.rb_end = 1'b1;
                n_state      = (i_sts.op == OP_INSERT) ? S_PL_START : S_RESP;
            end
            S_PL_START: begin
                o_cmd.pl_start = 1'b1;
                n_state        = S_PL_RD;
            end
            S_PL_RD: begin
                o_cmd.pl_rd = 1'b1;
                n_state     = S_PL_CHK;
            end
            S_PL_CHK: begin
                if (!i_sts.occ) begin
                    o_cmd.pl_wr = 1'b1;
                    n_state     = S_RESP;
                end else if (i_sts.key_eq_req || i_sts.n_last) begin
                    // refused: give back the count raised before the probe
                    o_cmd.dec_cnt = 1'b1;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_PL_RD;
                end
            end
            S_PR_RD: begin
                o_cmd.pr_rd = 1'b1;
                n_state     = S_PR_CHK;
            end
            S_PR_CHK: begin
                if (i_sts.occ && i_sts.key_eq_req) begin
                    if (i_sts.op == OP_REMOVE) begin
                        o_cmd.rm_start = 1'b1;
                        n_state        = S_RM_TOP;
                    end else begin
                        o_cmd.set_found = 1'b1;
                        n_state         = S_RESP;
                    end
                end else if (!i_sts.occ || i_sts.n_last) begin
                    n_state = (i_sts.op == OP_REMOVE) ? S_RSZ : S_RESP;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_PR_RD;
                end
            end
            S_RM_TOP: begin
                if (i_sts.rm_done) begin
                    n_state = S_RM_END;
                end else begin
                    o_cmd.rm_rd = 1'b1;
                    n_state     = S_RM_CHK;
                end
            end
            S_RM_CHK: begin
                if (!i_sts.occ) begin
                    n_state = S_RM_END;
                end else begin
                    o_cmd.rm_step = 1'b1;
                    n_state       = S_RM_TOP;
                end
            end
            S_RM_END: begin
                o_cmd.rm_end = 1'b1;
                n_state      = S_RSZ;
            end
            S_RESP: begin
                if (!r_ovalid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("request latched outside idle");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_ovalid || i_ready))
        else $error("result overwritten before transaction");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second request taken without work");

endmodule

/* design/linear_probe_hash_table_core.sv */
// A find probes linearly from the home bucket; an insert adds a probe and a remove a
// backward-shift walk, and either may add a rebuild of the table into the other half.
// One request at a time, taken only in idle; the entry memory has a single read port.
// Reset: synchronous active low; then a clearing pass over the first INIT_CAPACITY (16)
// entries of the live half runs before the first request is taken.
module linear_probe_hash_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_key,
    input  logic [31:0] i_key_hash,
    input  logic [31:0] i_payload,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic        o_full_res,
    output logic [31:0] o_found_value,
    output logic [10:0] o_entry_count,
    output logic [10:0] o_table_capacity
);
    import lpht_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lpht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lpht_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_op             (i_op),
        .i_key            (i_key),
        .i_key_hash       (i_key_hash),
        .i_payload        (i_payload),
        .o_hit            (o_hit),
        .o_full_res       (o_full_res),
        .o_found_value    (o_found_value),
        .o_entry_count    (o_entry_count),
        .o_table_capacity (o_table_capacity)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

class lpht_scoreboard;
    typedef struct packed {
        logic        hit;
        logic        full_res;
        logic [31:0] found_value;
        logic [10:0] entry_count;
        logic [10:0] table_capacity;
    } t_answer;

    localparam int NSLOT = lpht_pkg::SLOTS;

    logic [31:0] bkt_key [2*NSLOT];
    logic [31:0] bkt_val [2*NSLOT];
    logic [31:0] bkt_hash[2*NSLOT];
    bit          bkt_occ [2*NSLOT];
    bit          side;
    int unsigned n_stored;
    int unsigned cap;
    t_answer     pending[$];
    int          n_err;

    function new();
        foreach (bkt_occ[i]) bkt_occ[i] = 0;
        side = 0;
        n_stored = 0;
        cap = lpht_pkg::INIT_CAPACITY;
        n_err = 0;
    endfunction

    function int unsigned base_of(bit h);
        return h ? NSLOT : 0;
    endfunction

    function int unsigned target_cap(int unsigned c);
        int unsigned n;
        int unsigned p;
        n = (c == 0) ? 1 : c;
        p = 1;
        while (p < n) p = p << 1;
        p = p << 1;
        if (p < lpht_pkg::INIT_CAPACITY) p = lpht_pkg::INIT_CAPACITY;
        if (p > lpht_pkg::MAX_CAPACITY) p = lpht_pkg::MAX_CAPACITY;
        return p;
    endfunction

    // 0 stored, 1 duplicate, 2 no room
    function int put(int unsigned b0, int unsigned c, logic [31:0] k, logic [31:0] v,
                     logic [31:0] h);
        int unsigned b;
        int unsigned s;
        b = h & (c - 1);
        for (int n = 0; n < c; n++) begin
            s = b0 + (b % NSLOT);
            if (!bkt_occ[s]) begin
                bkt_occ[s] = 1;
                bkt_key[s] = k;
                bkt_val[s] = v;
                bkt_hash[s] = h;
                return 0;
            end
            if (bkt_key[s] == k) return 1;
            b = (b + 1) & (c - 1);
        end
        return 2;
    endfunction

    function bit lookup(logic [31:0] k, logic [31:0] h, output int unsigned slot);
        int unsigned b;
        int unsigned s;
        slot = 0;
        b = h & (cap - 1);
        for (int n = 0; n < cap; n++) begin
            s = base_of(side) + (b % NSLOT);
            if (!bkt_occ[s]) return 0;
            if (bkt_key[s] == k) begin
                slot = b % NSLOT;
                return 1;
            end
            b = (b + 1) & (cap - 1);
        end
        return 0;
    endfunction

    function void regrow();
        int unsigned r;
        int unsigned ob;
        int unsigned nb;
        int          dummy;
        r = target_cap(n_stored);
        if (r > cap || r < (cap >> 1)) begin
            ob = base_of(side);
            nb = base_of(!side);
            for (int i = 0; i < NSLOT; i++) bkt_occ[nb+i] = 0;
            for (int i = 0; i < cap && i < NSLOT; i++)
                if (bkt_occ[ob+i])
                    dummy = put(nb, r, bkt_key[ob+i], bkt_val[ob+i], bkt_hash[ob+i]);
            for (int i = 0; i < NSLOT; i++) bkt_occ[ob+i] = 0;
            cap = r;
            side = !side;
        end
    endfunction

    // backward-shift deletion from bucket b
    function void erase(int unsigned b);
        int unsigned m;
        int unsigned b0;
        int unsigned prev;
        int unsigned cur;
        int unsigned s;
        int unsigned home;
        bit          mv;
        m = cap - 1;
        b0 = base_of(side);
        prev = b;
        cur = ((b + 1) & m) % NSLOT;
        for (int n = 1; n < cap; n++) begin
            s = b0 + cur;
            if (!bkt_occ[s]) break;
            home = bkt_hash[s] & m;
            mv = (prev < cur && (home <= prev || home > cur)) ||
                 (prev > cur && home <= prev && home > cur);
            if (mv) begin
                bkt_key[b0+prev] = bkt_key[s];
                bkt_val[b0+prev] = bkt_val[s];
                bkt_hash[b0+prev] = bkt_hash[s];
                prev = cur;
            end
            cur = ((cur + 1) & m) % NSLOT;
        end
        bkt_occ[b0+prev] = 0;
    endfunction

    function void note_request(lpht_pkg::t_op op, logic [31:0] k, logic [31:0] h,
                               logic [31:0] v);
        t_answer     a;
        int unsigned slot;
        a = '0;
        case (op)
            lpht_pkg::OP_FIND: begin
                if (lookup(k, h, slot)) begin
                    a.hit = 1;
                    a.found_value = bkt_val[base_of(side) + slot];
                end
            end
            lpht_pkg::OP_INSERT: begin
                if (n_stored >= lpht_pkg::MAX_CAPACITY) begin
                    a.full_res = 1;
                end else begin
                    n_stored++;
                    regrow();
                    if (put(base_of(side), cap, k, v, h) == 0) a.hit = 1;
                    else n_stored--;
                end
            end
            lpht_pkg::OP_REMOVE: begin
                if (lookup(k, h, slot)) begin
                    erase(slot);
                    if (n_stored > 0) n_stored--;
                    a.hit = 1;
                end
                regrow();
            end
            default: ;
        endcase
        a.entry_count = n_stored[10:0];
        a.table_capacity = cap[10:0];
        pending.push_back(a);
    endfunction

    function void check_answer(t_answer got);
        t_answer w;
        if (pending.size() == 0) begin
            n_err++;
            if (n_err <= 10) $display("unexpected transaction: %p", got);
            return;
        end
        w = pending.pop_front();
        if (got !== w) begin
            n_err++;
            if (n_err <= 10)
                $display("mismatch: exp %0d %0d %h %0d %0d | got %0d %0d %h %0d %0d",
                         w.hit, w.full_res, w.found_value, w.entry_count, w.table_capacity,
                         got.hit, got.full_res, got.found_value, got.entry_count,
                         got.table_capacity);
        end
    endfunction
endclass

module tb_top;
    import lpht_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_op;
    logic [31:0] i_key;
    logic [31:0] i_key_hash;
    logic [31:0] i_payload;
    logic        o_valid;
    logic        i_ready;
    logic        o_hit;
    logic        o_full_res;
    logic [31:0] o_found_value;
    logic [10:0] o_entry_count;
    logic [10:0] o_table_capacity;

    lpht_scoreboard table_sb;
    logic [31:0]    live_keys[$];
    bit             hold_rx;
    int             quiet_cycles;

    localparam int QUIET_LIMIT = 200000;

    linear_probe_hash_table_core u_top (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // cheap hash so that chains form: the key XORed with itself shifted right by 7
    function automatic logic [31:0] hash_of(logic [31:0] k);
        return k ^ (k >> 7);
    endfunction

    // called and left at a falling edge; valid drops only when a gap follows
    task automatic send(t_op op, logic [31:0] k, logic [31:0] h, logic [31:0] v);
        int n_idle;
        n_idle = $urandom_range(0, 5);
        if (n_idle > 0) begin
            i_valid <= 0;
            repeat (n_idle) @(negedge i_clk);
        end
        i_valid <= 1;
        i_op <= op;
        i_key <= k;
        i_key_hash <= h;
        i_payload <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        table_sb.note_request(op, k, h, v);
        @(negedge i_clk);
    endtask

    task automatic send_keyed(t_op op, logic [31:0] k);
        send(op, k, hash_of(k), $urandom());
    endtask

    task automatic random_mix(int n, int ins_weight, int key_span);
        int          r;
        int          ix;
        logic [31:0] k;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < ins_weight) begin
                k = (key_span > 0) ? $urandom_range(0, key_span) : $urandom();
                live_keys.push_back(k);
                send_keyed(OP_INSERT, k);
            end else if (r < ins_weight + 25 && live_keys.size() > 0) begin
                ix = $urandom_range(0, live_keys.size() - 1);
                k = live_keys[ix];
                live_keys.delete(ix);
                send_keyed(OP_REMOVE, k);
            end else if (r < 97 && live_keys.size() > 0) begin
                send_keyed(OP_FIND, live_keys[$urandom_range(0, live_keys.size() - 1)]);
            end else if (r < 99) begin
                // absent keys and arbitrary hashes
                send(t_op'($urandom_range(0, 2)), $urandom(), $urandom(), $urandom());
            end else begin
                send(OP_NOP, $urandom(), $urandom(), $urandom());
            end
        end
    endtask

    // receiver
    initial begin
        i_ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_ready <= 0;
            end else if ($urandom_range(0, 3) == 0) begin
                i_ready <= 0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                i_ready <= 1;
            end else begin
                i_ready <= 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            table_sb.check_answer({o_hit, o_full_res, o_found_value, o_entry_count,
                                   o_table_capacity});
    end

    // watchdog on transactions
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || hold_rx)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** linear_probe_hash_table_core: FAILED **");
            $finish;
        end
    end

    initial begin
        table_sb = new();
        hold_rx = 0;
        quiet_cycles = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_op = OP_NOP;
        i_key = '0;
        i_key_hash = '0;
        i_payload = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, all ops, duplicates, absent removes, nop
        send(OP_FIND, 32'h0, 32'h0, 32'h0);
        send(OP_REMOVE, 32'h0, 32'h0, 32'h0);
        send(OP_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send(OP_INSERT, 32'h0, 32'h0, 32'h1234_5678);
        send(OP_INSERT, 32'h10, 32'h0, 32'hA5A5_A5A5);
        send(OP_INSERT, 32'h20, 32'hF, 32'h5A5A_5A5A);
        send(OP_FIND, 32'h0, 32'h0, 32'h0);
        send(OP_FIND, 32'h10, 32'h0, 32'h0);
        send(OP_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send(OP_REMOVE, 32'h0, 32'h0, 32'h0);
        send(OP_FIND, 32'h10, 32'h0, 32'h0);
        send(OP_REMOVE, 32'h1234, 32'h0, 32'h0);
        send(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++) send(OP_INSERT, 32'h100 + i, i * 3, i);
        send(OP_REMOVE, 32'h10, 32'h0, 32'h0);
        send(OP_REMOVE, 32'h20, 32'hF, 32'h0);

        // fill with a stalled receiver so the input backs up
        fork
            begin
                hold_rx = 1;
                repeat (400) @(posedge i_clk);
                hold_rx = 0;
            end
            random_mix(30, 70, 0);
        join

        // remove-heavy mix with a narrow key span: duplicates and shrinking
        random_mix(60, 10, 40);
        // grow to the full store, hit the refusal
        for (int i = 0; table_sb.n_stored < MAX_CAPACITY; i++) begin
            live_keys.push_back(32'h8000_0000 + i);
            send(OP_INSERT, 32'h8000_0000 + i, $urandom(), $urandom());
        end
        for (int i = 0; i < 5; i++) send(OP_INSERT, $urandom(), $urandom(), $urandom());
        random_mix(20, 10, 0);
        i_valid <= 0;

        while (table_sb.pending.size() > 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
        if (table_sb.n_err == 0 && table_sb.pending.size() == 0)
            $display("** linear_probe_hash_table_core: PASSED **");
        else
            $display("** linear_probe_hash_table_core: FAILED **");
        $finish;
    end
endmodule
